// ----- hdl/scrs_pkg.sv -----
// ----------------------------------------------------------------------------
// scrs_pkg
// Shared constants for the slide copy relay sequencer: reset values,
// display codes and configuration register indexes.
// ----------------------------------------------------------------------------
package scrs_pkg;

    localparam int unsigned TICK_W  = 16;
    localparam int unsigned COUNT_W = 8;
    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [TICK_W-1:0]  RST_PHASE_ZERO  = 16'd255;
    localparam logic [TICK_W-1:0]  RST_PHASE_ONE   = 16'd2048;
    localparam logic [TICK_W-1:0]  RST_PHASE_TWO   = 16'd255;
    localparam logic [TICK_W-1:0]  RST_PHASE_THREE = 16'd512;
    localparam logic [COUNT_W-1:0] RST_PRESET_SMALL  = 8'd36;
    localparam logic [COUNT_W-1:0] RST_PRESET_MEDIUM = 8'd80;
    localparam logic [COUNT_W-1:0] RST_PRESET_LARGE  = 8'd144;
    localparam logic [TICK_W-1:0]  RST_COUNTDOWN = 16'd255;
    localparam logic [COUNT_W-1:0] RST_SLIDES    = 8'd80;

    typedef logic [3:0] t_digit_code;
    localparam t_digit_code CODE_BLANK = 4'd10;
    localparam t_digit_code CODE_PLAY  = 4'd11;
    localparam t_digit_code CODE_PAUSE = 4'd12;

    typedef logic [1:0] t_phase;
    localparam t_phase PHASE_ADVANCE = 2'd0;
    localparam t_phase PHASE_SHUTTER = 2'd2;
    localparam t_phase PHASE_LAST    = 2'd3;

    typedef logic [1:0] t_digit_pos;
    localparam t_digit_pos POS_MARK     = 2'd0;
    localparam t_digit_pos POS_HUNDREDS = 2'd1;
    localparam t_digit_pos POS_TENS     = 2'd2;
    localparam t_digit_pos POS_UNITS    = 2'd3;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx REG_PHASE_ZERO    = 3'd0;
    localparam t_cfg_idx REG_PHASE_ONE     = 3'd1;
    localparam t_cfg_idx REG_PHASE_TWO     = 3'd2;
    localparam t_cfg_idx REG_PHASE_THREE   = 3'd3;
    localparam t_cfg_idx REG_PRESET_SMALL  = 3'd4;
    localparam t_cfg_idx REG_PRESET_MEDIUM = 3'd5;
    localparam t_cfg_idx REG_PRESET_LARGE  = 3'd6;

endpackage

// ----- hdl/slide_copy_relay_sequencer.sv -----
// ----------------------------------------------------------------------------
// slide_copy_relay_sequencer
// Timed advance/shutter relay cycle per slide with a slide countdown, play
// and count buttons, and a four-position multiplexed display digit per tick.
// ----------------------------------------------------------------------------
// One request is one millisecond tick carrying the two button press flags;
// each request gives exactly one result, held in an output register. A new
// request is taken every cycle unless that output register is full and
// stalled, so without output stalls the rate is one request per clock. The
// state update and the decimal split of the count are combinational logic.
// Configuration writes take effect at the next clock edge.
module slide_copy_relay_sequencer
    import scrs_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [TICK_W-1:0]    i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_play_press,
    input  logic                 i_count_press,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_advance_relay,
    output logic                 o_shutter_relay,
    output logic [1:0]           o_digit_position,
    output logic [3:0]           o_digit_code,
    output logic                 o_playing,
    output logic [COUNT_W-1:0]   o_slides_remaining
);

    logic [TICK_W-1:0]  r_phase_ticks [4];
    logic [COUNT_W-1:0] r_preset_small, r_preset_medium, r_preset_large;

    logic               r_play_mode, n_play_mode;
    t_phase             r_phase, n_phase;
    logic [TICK_W-1:0]  r_countdown, n_countdown;
    logic [COUNT_W-1:0] r_slides, n_slides;
    t_digit_pos         r_disp_idx;

    logic               r_out_valid;
    logic               r_adv, n_adv, r_shut, n_shut;
    t_digit_pos         r_pos;
    t_digit_code        r_code, n_code;
    logic               r_out_play;
    logic [COUNT_W-1:0] r_out_slides;

    logic               accept;
    logic [1:0]         hundreds;
    logic [6:0]         rem100;
    logic [3:0]         tens, units;
    logic [17:0]        tens_prod;
    logic [TICK_W-1:0]  cd_dec;
    logic [COUNT_W-1:0] slides_dec;

    assign o_in_stall = r_out_valid & i_out_stall;
    assign accept     = i_in_valid & ~o_in_stall;

    // decimal split of the count at the start of the tick
    always_comb begin
        if (r_slides >= 8'd200) begin
            hundreds = 2'd2;
            rem100   = 7'(r_slides - 8'd200);
        end else if (r_slides >= 8'd100) begin
            hundreds = 2'd1;
            rem100   = 7'(r_slides - 8'd100);
        end else begin
            hundreds = 2'd0;
            rem100   = r_slides[6:0];
        end
        tens_prod = 18'(rem100) * 18'd205;
        tens      = tens_prod[14:11];
        units     = 4'(7'(rem100 - 7'(tens) * 7'd10));
    end

    always_comb begin
        case (r_disp_idx)
            POS_MARK:     n_code = r_play_mode ? CODE_PLAY : CODE_PAUSE;
            POS_HUNDREDS: n_code = (hundreds == 2'd0) ? CODE_BLANK : t_digit_code'(hundreds);
            POS_TENS:     n_code = (hundreds == 2'd0 && tens == 4'd0) ? CODE_BLANK : tens;
            default:      n_code = units;
        endcase
    end

    always_comb begin
        n_play_mode = r_play_mode;
        n_phase     = r_phase;
        n_countdown = r_countdown;
        n_slides    = r_slides;
        n_adv       = 1'b0;
        n_shut      = 1'b0;
        cd_dec      = (r_countdown != '0) ? r_countdown - 1'b1 : r_countdown;
        slides_dec  = r_slides - 1'b1;

        if (r_play_mode) begin
            n_countdown = cd_dec;
            n_adv       = (r_phase == PHASE_ADVANCE);
            n_shut      = (r_phase == PHASE_SHUTTER);
            if (cd_dec == '0) begin
                if (r_phase != PHASE_LAST) begin
                    n_phase     = r_phase + 1'b1;
                    n_countdown = r_phase_ticks[r_phase + 1'b1];
                end else begin
                    n_phase     = PHASE_ADVANCE;
                    n_countdown = r_phase_ticks[PHASE_ADVANCE];
                    n_slides    = slides_dec;
                    if (slides_dec == '0) begin
                        n_play_mode = 1'b0;
                    end
                end
            end
        end

        if (i_play_press) begin
            n_play_mode = ~n_play_mode;
        end
        if (i_count_press) begin
            n_play_mode = 1'b0;
            if (n_slides < r_preset_small) begin
                n_slides = r_preset_small;
            end else if (n_slides < r_preset_medium) begin
                n_slides = r_preset_medium;
            end else if (n_slides < r_preset_large) begin
                n_slides = r_preset_large;
            end else begin
                n_slides = r_preset_small;
            end
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_ticks[0] <= RST_PHASE_ZERO;
            r_phase_ticks[1] <= RST_PHASE_ONE;
            r_phase_ticks[2] <= RST_PHASE_TWO;
            r_phase_ticks[3] <= RST_PHASE_THREE;
            r_preset_small   <= RST_PRESET_SMALL;
            r_preset_medium  <= RST_PRESET_MEDIUM;
            r_preset_large   <= RST_PRESET_LARGE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_PHASE_ZERO:    r_phase_ticks[0] <= i_cfg_data;
                REG_PHASE_ONE:     r_phase_ticks[1] <= i_cfg_data;
                REG_PHASE_TWO:     r_phase_ticks[2] <= i_cfg_data;
                REG_PHASE_THREE:   r_phase_ticks[3] <= i_cfg_data;
                REG_PRESET_SMALL:  r_preset_small   <= i_cfg_data[COUNT_W-1:0];
                REG_PRESET_MEDIUM: r_preset_medium  <= i_cfg_data[COUNT_W-1:0];
                REG_PRESET_LARGE:  r_preset_large   <= i_cfg_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_play_mode <= 1'b0;
            r_phase     <= PHASE_ADVANCE;
            r_countdown <= RST_COUNTDOWN;
            r_slides    <= RST_SLIDES;
            r_disp_idx  <= POS_MARK;
        end else if (accept) begin
            r_play_mode <= n_play_mode;
            r_phase     <= n_phase;
            r_countdown <= n_countdown;
            r_slides    <= n_slides;
            r_disp_idx  <= r_disp_idx + 1'b1;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_adv        <= n_adv;
            r_shut       <= n_shut;
            r_pos        <= r_disp_idx;
            r_code       <= n_code;
            r_out_play   <= n_play_mode;
            r_out_slides <= n_slides;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_advance_relay    = r_adv;
    assign o_shutter_relay    = r_shut;
    assign o_digit_position   = r_pos;
    assign o_digit_code       = r_code;
    assign o_playing          = r_out_play;
    assign o_slides_remaining = r_out_slides;

endmodule

// ----- tb/sv/scrs_tick_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// scrs_tick_checker
// Watches the request, result and register write channels of the slide copy
// relay sequencer, predicts every result from its own copy of the relay phase
// machine, count and display state, and compares field by field in order.
// ----------------------------------------------------------------------------
module scrs_tick_checker
    import scrs_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  t_cfg_idx             i_cfg_index,
    input  logic [TICK_W-1:0]    i_cfg_data,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  logic                 i_play_press,
    input  logic                 i_count_press,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  logic                 i_advance_relay,
    input  logic                 i_shutter_relay,
    input  logic [1:0]           i_digit_position,
    input  logic [3:0]           i_digit_code,
    input  logic                 i_playing,
    input  logic [COUNT_W-1:0]   i_slides_remaining,
    output int                   o_pending,
    output int                   o_checked,
    output int                   o_failures
);

    typedef struct packed {
        logic               adv;
        logic               shut;
        t_digit_pos         pos;
        t_digit_code        code;
        logic               playing;
        logic [COUNT_W-1:0] slides;
    } t_tick_result;

    t_tick_result       tick_results_due[$];

    logic [TICK_W-1:0]  phase_len [4];
    logic [COUNT_W-1:0] preset_first;
    logic [COUNT_W-1:0] preset_second;
    logic [COUNT_W-1:0] preset_third;

    logic               run_mode;
    t_phase             cur_phase;
    logic [TICK_W-1:0]  countdown;
    logic [COUNT_W-1:0] slides;
    t_digit_pos         disp_pos;

    int                 pending_cnt = 0;
    int                 checked_cnt = 0;
    int                 fail_count = 0;

    assign o_pending  = pending_cnt;
    assign o_checked  = checked_cnt;
    assign o_failures = fail_count;

    task automatic relay_tick(input logic play_in, input logic count_in,
                              output t_tick_result r);
        int unsigned hund;
        int unsigned tens_d;
        int unsigned unit_d;
        t_digit_code codes [4];
        hund   = slides / 100;
        tens_d = (slides / 10) % 10;
        unit_d = slides % 10;
        codes[POS_MARK]     = run_mode ? CODE_PLAY : CODE_PAUSE;
        codes[POS_HUNDREDS] = (hund == 0) ? CODE_BLANK : t_digit_code'(hund);
        codes[POS_TENS]     = (hund == 0 && tens_d == 0) ? CODE_BLANK
                                                          : t_digit_code'(tens_d);
        codes[POS_UNITS]    = t_digit_code'(unit_d);
        r = '0;
        if (run_mode) begin
            if (countdown != 0)
                countdown = countdown - 1'b1;
            r.adv  = (cur_phase == PHASE_ADVANCE);
            r.shut = (cur_phase == PHASE_SHUTTER);
            if (countdown == 0) begin
                if (cur_phase != PHASE_LAST) begin
                    cur_phase = cur_phase + 1'b1;
                    countdown = phase_len[cur_phase];
                end else begin
                    slides    = slides - 1'b1;
                    cur_phase = PHASE_ADVANCE;
                    countdown = phase_len[PHASE_ADVANCE];
                    if (slides == 0)
                        run_mode = 1'b0;
                end
            end
        end
        r.pos  = disp_pos;
        r.code = codes[disp_pos];
        disp_pos = disp_pos + 1'b1;
        if (play_in)
            run_mode = !run_mode;
        if (count_in) begin
            run_mode = 1'b0;
            if (slides < preset_first)
                slides = preset_first;
            else if (slides < preset_second)
                slides = preset_second;
            else if (slides < preset_third)
                slides = preset_third;
            else
                slides = preset_first;
        end
        r.playing = run_mode;
        r.slides  = slides;
    endtask

    task automatic compare_field(input string label, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, label, want, got);
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_tick_result got;
        t_tick_result want;
        t_tick_result predicted;
        if (!i_rst_n) begin
            phase_len[0]  = RST_PHASE_ZERO;
            phase_len[1]  = RST_PHASE_ONE;
            phase_len[2]  = RST_PHASE_TWO;
            phase_len[3]  = RST_PHASE_THREE;
            preset_first  = RST_PRESET_SMALL;
            preset_second = RST_PRESET_MEDIUM;
            preset_third  = RST_PRESET_LARGE;
            run_mode      = 1'b0;
            cur_phase     = PHASE_ADVANCE;
            countdown     = RST_COUNTDOWN;
            slides        = RST_SLIDES;
            disp_pos      = POS_MARK;
            tick_results_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index) inside
                    REG_PHASE_ZERO, REG_PHASE_ONE, REG_PHASE_TWO, REG_PHASE_THREE: begin
                        phase_len[i_cfg_index[1:0]] = i_cfg_data;
                    end
                    REG_PRESET_SMALL:  preset_first  = i_cfg_data[COUNT_W-1:0];
                    REG_PRESET_MEDIUM: preset_second = i_cfg_data[COUNT_W-1:0];
                    REG_PRESET_LARGE:  preset_third  = i_cfg_data[COUNT_W-1:0];
                    default: ;
                endcase
            end
            // a result leaving now belongs to an earlier request
            if (i_out_valid && !i_out_stall) begin
                got = '{adv: i_advance_relay, shut: i_shutter_relay,
                        pos: i_digit_position, code: i_digit_code,
                        playing: i_playing, slides: i_slides_remaining};
                if (tick_results_due.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected result, expected none, got %h", $time, got);
                end else begin
                    want = tick_results_due.pop_front();
                    compare_field("advance_relay", want.adv, got.adv);
                    compare_field("shutter_relay", want.shut, got.shut);
                    compare_field("digit_position", want.pos, got.pos);
                    compare_field("digit_code", want.code, got.code);
                    compare_field("playing", want.playing, got.playing);
                    compare_field("slides_remaining", want.slides, got.slides);
                end
                checked_cnt++;
            end
            if (i_in_valid && !i_in_stall) begin
                relay_tick(i_play_press, i_count_press, predicted);
                tick_results_due.push_back(predicted);
            end
        end
        pending_cnt = tick_results_due.size();
    end

endmodule

// ----- tb/sv/tb_slide_copy_relay_sequencer.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_slide_copy_relay_sequencer
// Drives button requests into the slide copy relay sequencer under several
// register settings (zero and full phase lengths, unordered and zero presets)
// with random gaps and output stalls, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_slide_copy_relay_sequencer;
    import scrs_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;

    logic               i_clk;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    t_cfg_idx           i_cfg_index = REG_PHASE_ZERO;
    logic [TICK_W-1:0]  i_cfg_data = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic               i_play_press = 1'b0;
    logic               i_count_press = 1'b0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic               o_advance_relay;
    logic               o_shutter_relay;
    logic [1:0]         o_digit_position;
    logic [3:0]         o_digit_code;
    logic               o_playing;
    logic [COUNT_W-1:0] o_slides_remaining;

    int                 pending;
    int                 checked;
    int                 failures;
    int                 ticks_sent = 0;
    int                 idle_cycles = 0;
    logic               tx_burst = 1'b0;

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    slide_copy_relay_sequencer dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_play_press       (i_play_press),
        .i_count_press      (i_count_press),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_advance_relay    (o_advance_relay),
        .o_shutter_relay    (o_shutter_relay),
        .o_digit_position   (o_digit_position),
        .o_digit_code       (o_digit_code),
        .o_playing          (o_playing),
        .o_slides_remaining (o_slides_remaining)
    );

    scrs_tick_checker tick_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .i_in_stall         (o_in_stall),
        .i_play_press       (i_play_press),
        .i_count_press      (i_count_press),
        .i_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .i_advance_relay    (o_advance_relay),
        .i_shutter_relay    (o_shutter_relay),
        .i_digit_position   (o_digit_position),
        .i_digit_code       (o_digit_code),
        .i_playing          (o_playing),
        .i_slides_remaining (o_slides_remaining),
        .o_pending          (pending),
        .o_checked          (checked),
        .o_failures         (failures)
    );

    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (i_in_valid && !o_in_stall)
                || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no request or result moved for %0d cycles", $time, idle_cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic send_tick(input logic play, input logic count);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 19);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_play_press  <= play;
        i_count_press <= count;
        @(posedge i_clk);
        while (!(i_in_valid && !o_in_stall))
            @(posedge i_clk);
        @(negedge i_clk);
        ticks_sent++;
    endtask

    task automatic drain;
        i_in_valid <= 1'b0;
        while (pending != 0)
            @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [TICK_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(negedge i_clk);
    endtask

    task automatic load_settings(input logic [TICK_W-1:0] t0, input logic [TICK_W-1:0] t1,
                                 input logic [TICK_W-1:0] t2, input logic [TICK_W-1:0] t3,
                                 input logic [COUNT_W-1:0] p0,
                                 input logic [COUNT_W-1:0] p1,
                                 input logic [COUNT_W-1:0] p2);
        drain();
        write_reg(REG_PHASE_ZERO, t0);
        write_reg(REG_PHASE_ONE, t1);
        write_reg(REG_PHASE_TWO, t2);
        write_reg(REG_PHASE_THREE, t3);
        write_reg(REG_PRESET_SMALL, TICK_W'(p0));
        write_reg(REG_PRESET_MEDIUM, TICK_W'(p1));
        write_reg(REG_PRESET_LARGE, TICK_W'(p2));
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic random_ticks(input int n, input int play_pct, input int count_pct);
        logic play;
        logic count;
        for (int k = 0; k < n; k++) begin
            if (k % 40 == 0)
                tx_burst = ($urandom_range(0, 3) == 0);
            play  = ($urandom_range(0, 99) < play_pct);
            count = ($urandom_range(0, 99) < count_pct);
            send_tick(play, count);
        end
    endtask

    // receiver: random stalls per result, one long hold to back up the block
    initial begin : result_sink
        int wait_n;
        int taken;
        logic rx_burst;
        taken    = 0;
        rx_burst = 1'b0;
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            if (taken % 64 == 0)
                rx_burst = ($urandom_range(0, 3) == 0);
            if (taken == 500)
                wait_n = 60;
            else
                wait_n = rx_burst ? 0 : $urandom_range(0, 19);
            if (wait_n != 0) begin
                i_out_stall <= 1'b1;
                repeat (wait_n) @(negedge i_clk);
            end
            i_out_stall <= 1'b0;
            @(posedge i_clk);
            while (!(o_out_valid && !i_out_stall))
                @(posedge i_clk);
            taken++;
            @(negedge i_clk);
        end
    end

    initial begin : stimulus
        // {play, count} per tick
        logic [1:0] opening [20] = '{
            2'b00, 2'b10, 2'b00, 2'b00, 2'b00, 2'b11, 2'b01, 2'b01, 2'b01, 2'b10,
            2'b10, 2'b11, 2'b00, 2'b10, 2'b00, 2'b00, 2'b00, 2'b01, 2'b00, 2'b00
        };
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (opening[k])
            send_tick(opening[k][1], opening[k][0]);

        // short phases to burn through the countdown left from reset
        load_settings(16'd3, 16'd5, 16'd2, 16'd7, 8'd20, 8'd60, 8'd200);
        random_ticks(300, 3, 1);

        // zero length phases, tiny presets: count runs out, play restarts at zero
        load_settings(16'd0, 16'd0, 16'd0, 16'd0, 8'd1, 8'd2, 8'd3);
        random_ticks(200, 6, 2);

        load_settings(16'($urandom_range(0, 7)), 16'($urandom_range(0, 7)),
                      16'($urandom_range(0, 7)), 16'($urandom_range(0, 7)),
                      8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                      8'($urandom_range(1, 255)));
        random_ticks(200, 4, 3);

        // unordered presets with a zero
        load_settings(16'd1, 16'd0, 16'd2, 16'd1, 8'd0, 8'd200, 8'd100);
        random_ticks(150, 5, 8);

        load_settings(16'($urandom_range(0, 5)), 16'($urandom_range(0, 5)),
                      16'($urandom_range(0, 5)), 16'($urandom_range(0, 5)),
                      8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                      8'($urandom_range(1, 255)));
        random_ticks(120, 5, 4);

        load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd255, 8'd255, 8'd255);
        random_ticks(60, 10, 10);

        drain();
        repeat (4) @(posedge i_clk);
        $display("covered %0d button ticks and %0d checked results", ticks_sent, checked);
        $display("over six register settings, zero and full phase lengths, one long hold");
        if (failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
